### hw/rtl/wsdm_pkg.sv
// Shared types and constants for the wheel speed and drive mode block.
// No dependencies; used by wsdm_div, wsdm_mode and the top module by scoped names.
package wsdm_pkg;

    // Fixed field widths
    localparam int SPEED_W = 16;
    localparam int SSPEED_W = 17;
    localparam int LIMIT_W = 16;
    localparam int CIRC_W = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int HOLD_W = 16;
    // circumference * 1000 fits in 23 bits
    localparam int NUM_W = CIRC_W + 10;
    // upper numerator bits checked for quotient overflow
    localparam int NUM_HI_W = NUM_W - SPEED_W;
    localparam int DIV_STEPS = SPEED_W;

    localparam logic [SPEED_W-1:0] SPEED_SAT = '1;

    // Register reset values
    localparam logic [LIMIT_W-1:0] STOP_LIMIT_RST = 16'd200;
    localparam logic [LIMIT_W-1:0] SWITCH_LIMIT_RST = 16'd100;
    localparam logic [CIRC_W-1:0] CIRC_RST = 13'd1596;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRC = 2'd2;

    // Drive modes
    typedef logic [2:0] mode_t;
    localparam mode_t MODE_PARK = 3'd0;
    localparam mode_t MODE_COAST_FWD = 3'd1;
    localparam mode_t MODE_COAST_BACK = 3'd2;
    localparam mode_t MODE_DRIVE = 3'd3;
    localparam mode_t MODE_RECUP_FWD = 3'd4;
    localparam mode_t MODE_RECUP_BACK = 3'd5;
    localparam mode_t MODE_REVERSE = 3'd6;

    // Pedal direction codes
    localparam logic [1:0] PED_NONE = 2'd0;
    localparam logic [1:0] PED_FWD = 2'd1;
    localparam logic [1:0] PED_BACK = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_DIV,
        ST_DONE
    } state_t;

    // Request into the mode tracker
    typedef struct packed {
        logic       upd;
        logic       sys;
        logic [1:0] ped;
    } mode_req_t;

    // Result of one mode update
    typedef struct packed {
        logic signed [SSPEED_W-1:0] signed_speed;
        mode_t                      mode;
        logic [HOLD_W-1:0]          hold;
        logic                       recup;
        logic                       rev;
    } mode_res_t;

endpackage

### hw/rtl/wsdm_period.sv
// Bit-serial pulse period unit: keeps the last pulse timestamp, forms the
// wrapped difference LSB first and scales it by 65/65536 on the fly.
// Depends on nothing but its parameters.
module wsdm_period #(
    parameter int TS_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TS_W-1:0]   now,
    output logic              done,
    output logic [TS_W-10:0]  period
);

    localparam int PER_W = TS_W - 9;
    // product 65*dt has TS_W+7 bits, one per cycle
    localparam int STEPS = TS_W + 7;
    localparam int K_W = $clog2(STEPS);
    localparam logic [K_W-1:0] K_LAST = K_W'(STEPS - 1);
    localparam logic [K_W-1:0] K_TS = K_W'(TS_W);
    localparam logic [K_W-1:0] K_LOW = K_W'(16);

    logic [TS_W-1:0]  now_sh_reg, now_sh_next;
    logic [TS_W-1:0]  last_reg, last_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             borrow_reg, borrow_next;
    logic             carry_reg, carry_next;
    logic [5:0]       dly_reg, dly_next;
    logic [PER_W-1:0] per_reg, per_next;

    logic       in_ts;
    logic       a_bit, b_bit, d_bit;
    logic [1:0] psum;

    // One bit of dt and one bit of 65*dt each cycle
    always_comb
    begin
        in_ts = (k_reg < K_TS);
        a_bit = now_sh_reg[0];
        b_bit = last_reg[0];
        d_bit = in_ts & (a_bit ^ b_bit ^ borrow_reg);
        psum = {1'b0, d_bit} + {1'b0, dly_reg[5]} + {1'b0, carry_reg};

        now_sh_next = now_sh_reg;
        last_next = last_reg;
        k_next = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        borrow_next = borrow_reg;
        carry_next = carry_reg;
        dly_next = dly_reg;
        per_next = per_reg;

        if (start)
        begin
            now_sh_next = now;
            k_next = '0;
            busy_next = 1'b1;
            borrow_next = 1'b0;
            carry_next = 1'b0;
            dly_next = '0;
            per_next = '0;
        end
        else if (busy_reg)
        begin
            // rotate both operands so they are restored after TS_W steps
            if (in_ts)
            begin
                now_sh_next = {now_sh_reg[0], now_sh_reg[TS_W-1:1]};
                last_next = {last_reg[0], last_reg[TS_W-1:1]};
                borrow_next = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & borrow_reg);
            end
            dly_next = {dly_reg[4:0], d_bit};
            carry_next = psum[1];
            // bits 16 and up of the product form the period
            if (k_reg >= K_LOW)
            begin
                per_next = {psum[0], per_reg[PER_W-1:1]};
            end
            k_next = k_reg + 1'b1;
            if (k_reg == K_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                last_next = now_sh_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            k_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            borrow_reg <= 1'b0;
            carry_reg <= 1'b0;
            dly_reg <= '0;
        end
        else
        begin
            last_reg <= last_next;
            k_reg <= k_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            borrow_reg <= borrow_next;
            carry_reg <= carry_next;
            dly_reg <= dly_next;
        end
    end

    // Payload shift registers
    always_ff @(posedge clk)
    begin
        now_sh_reg <= now_sh_next;
        per_reg <= per_next;
    end

    assign done = done_reg;
    assign period = per_reg;

endmodule

### hw/rtl/wsdm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, with an up-front
// overflow check that saturates the speed quotient. Uses wsdm_pkg.
module wsdm_div #(
    parameter int PER_W = 23
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [PER_W-1:0]              period,
    input  logic [wsdm_pkg::NUM_W-1:0]    num,
    output logic                          done,
    output logic [wsdm_pkg::SPEED_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(wsdm_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(wsdm_pkg::DIV_STEPS - 1);

    logic [PER_W-1:0]             rem_reg, rem_next;
    logic [PER_W-1:0]             div_reg, div_next;
    logic [wsdm_pkg::SPEED_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    logic [PER_W-1:0] num_hi;
    logic             sat;
    logic [PER_W:0]   trial;
    logic [PER_W:0]   diff;
    logic             ge;

    always_comb
    begin
        num_hi = PER_W'(num[wsdm_pkg::NUM_W-1:wsdm_pkg::SPEED_W]);
        // zero period or a quotient above the speed range saturates
        sat = (period == '0) || (num_hi >= period);
        trial = {rem_reg, q_reg[wsdm_pkg::SPEED_W-1]};
        diff = trial - {1'b0, div_reg};
        ge = (trial >= {1'b0, div_reg});

        rem_next = rem_reg;
        div_next = div_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            div_next = period;
            cnt_next = '0;
            if (sat)
            begin
                q_next = wsdm_pkg::SPEED_SAT;
                done_next = 1'b1;
            end
            else
            begin
                rem_next = num_hi;
                q_next = num[wsdm_pkg::SPEED_W-1:0];
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            // shift-subtract step
            rem_next = ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
            q_next = {q_reg[wsdm_pkg::SPEED_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;

endmodule

### hw/rtl/wsdm_mode.sv
// Drive mode tracker: classifies a candidate mode per tick, counts how long
// it holds and commits it past the switch limit. Uses wsdm_pkg.
module wsdm_mode #(
    parameter int CNT_W = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsdm_pkg::mode_req_t           req,
    input  logic [wsdm_pkg::SPEED_W-1:0]  speed,
    input  logic [wsdm_pkg::LIMIT_W-1:0]  switch_limit,
    output wsdm_pkg::mode_res_t           res
);

    localparam int CMP_W = (CNT_W > wsdm_pkg::HOLD_W) ? CNT_W : wsdm_pkg::HOLD_W;

    wsdm_pkg::mode_t  committed_reg, committed_next;
    wsdm_pkg::mode_t  cand_reg, cand_next;
    wsdm_pkg::mode_t  prev_reg, prev_next;
    logic [CNT_W-1:0] same_reg, same_next;

    logic            zero, back, neg, pos;
    logic            cls_ok;
    wsdm_pkg::mode_t cls;
    logic [CMP_W-1:0] same_ext;

    // Sign from the mode committed before this tick
    always_comb
    begin
        zero = (speed == '0);
        back = (committed_reg == wsdm_pkg::MODE_COAST_BACK)
            || (committed_reg == wsdm_pkg::MODE_RECUP_BACK)
            || (committed_reg == wsdm_pkg::MODE_REVERSE);
        neg = !zero && back;
        pos = !zero && !neg;
    end

    // Classification, first match wins
    always_comb
    begin
        cls_ok = 1'b1;
        cls = wsdm_pkg::MODE_PARK;
        if (zero && req.ped == wsdm_pkg::PED_NONE)
        begin
            cls = wsdm_pkg::MODE_PARK;
        end
        else if (req.sys)
        begin
            if (pos && req.ped == wsdm_pkg::PED_NONE)
                cls = wsdm_pkg::MODE_COAST_FWD;
            else if (neg && req.ped == wsdm_pkg::PED_NONE)
                cls = wsdm_pkg::MODE_COAST_BACK;
            else if (!neg && req.ped == wsdm_pkg::PED_FWD)
                cls = wsdm_pkg::MODE_DRIVE;
            else if (pos && req.ped == wsdm_pkg::PED_BACK)
                cls = wsdm_pkg::MODE_RECUP_FWD;
            else if (neg && req.ped == wsdm_pkg::PED_FWD)
                cls = wsdm_pkg::MODE_RECUP_BACK;
            else if (!pos && req.ped == wsdm_pkg::PED_BACK)
                cls = wsdm_pkg::MODE_REVERSE;
            else
                cls_ok = 1'b0;
        end
        else
        begin
            cls_ok = 1'b0;
        end
    end

    // Hold counter and commit
    always_comb
    begin
        if (cand_reg == prev_reg)
            same_next = (same_reg == '1) ? same_reg : same_reg + 1'b1;
        else
            same_next = '0;
        same_ext = CMP_W'(same_next);
        prev_next = cand_reg;
        cand_next = cand_reg;
        committed_next = committed_reg;
        if (cls_ok)
        begin
            cand_next = cls;
            if (same_ext > CMP_W'(switch_limit))
                committed_next = cls;
        end
    end

    // Result of this tick
    always_comb
    begin
        res.signed_speed = neg ? -$signed({1'b0, speed}) : $signed({1'b0, speed});
        res.mode = committed_next;
        res.hold = same_ext[wsdm_pkg::HOLD_W-1:0];
        res.recup = (committed_next == wsdm_pkg::MODE_RECUP_FWD)
            || (committed_next == wsdm_pkg::MODE_RECUP_BACK);
        res.rev = (committed_next == wsdm_pkg::MODE_REVERSE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_reg <= wsdm_pkg::MODE_PARK;
            cand_reg <= wsdm_pkg::MODE_PARK;
            prev_reg <= wsdm_pkg::MODE_PARK;
            same_reg <= '0;
        end
        else if (req.upd)
        begin
            committed_reg <= committed_next;
            cand_reg <= cand_next;
            prev_reg <= prev_next;
            same_reg <= same_next;
        end
    end

endmodule

### hw/rtl/wheel_speed_and_drive_mode.sv
// Wheel speed and drive mode, one item per control tick. A tick without a
// reed pulse goes straight to the done state, where its result is written to
// the output register, and the input is taken again once the sequencer is back
// in idle. A tick with a pulse first passes the period and divide states: the
// pulse period is formed and scaled by 65/65536 one bit per cycle, then a
// restoring divider produces the 16-bit speed one bit per cycle. When the
// speed saturates the divider skips its shift-subtract steps. One item is in
// work at a time; a finished result waits in the output register while the
// next item is taken, and a second finished item waits until the output
// register is free. Uses wsdm_pkg, wsdm_period, wsdm_div and wsdm_mode.
module wheel_speed_and_drive_mode #(
    parameter int TIMESTAMP_BITS = 32,
    parameter int COUNTER_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wsdm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wsdm_pkg::CFG_DATA_W-1:0]        cfg_data,
    // tick items
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   reed_event,
    input  logic [TIMESTAMP_BITS-1:0]              time_now_us,
    input  logic                                   system_on,
    input  logic [1:0]                             pedaling,
    // result items
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [wsdm_pkg::SSPEED_W-1:0]   signed_speed_mm_s,
    output logic [2:0]                             drive_mode,
    output logic [wsdm_pkg::HOLD_W-1:0]            hold_ticks,
    output logic                                   recuperation_active,
    output logic                                   reverse_active
);

    localparam int PER_W = TIMESTAMP_BITS - 9;
    localparam int CMP_W = (COUNTER_BITS > wsdm_pkg::LIMIT_W) ? COUNTER_BITS
                                                              : wsdm_pkg::LIMIT_W;

    wsdm_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [wsdm_pkg::LIMIT_W-1:0] stop_limit_reg;
    logic [wsdm_pkg::LIMIT_W-1:0] switch_limit_reg;
    logic [wsdm_pkg::CIRC_W-1:0]  circ_reg;

    // tick state
    logic [COUNTER_BITS-1:0]      tsp_reg, tsp_next;
    logic [wsdm_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic                         reed_reg;
    logic                         sys_reg;
    logic [1:0]                   ped_reg;

    // output register
    logic                                 out_valid_reg, out_valid_next;
    logic signed [wsdm_pkg::SSPEED_W-1:0] sspeed_reg;
    wsdm_pkg::mode_t                      mode_reg;
    logic [wsdm_pkg::HOLD_W-1:0]          hold_reg;
    logic                                 recup_reg;
    logic                                 rev_reg;

    logic                         accept;
    logic                         per_start, div_start, commit;
    logic                         per_done, div_done;
    logic [PER_W-1:0]             period;
    logic [wsdm_pkg::NUM_W-1:0]   num;
    logic [wsdm_pkg::SPEED_W-1:0] quotient;
    logic                         out_free;
    logic [COUNTER_BITS-1:0]      tsp_inc;
    wsdm_pkg::mode_req_t          mode_req;
    wsdm_pkg::mode_res_t          mode_res;

    assign cfg_ready = 1'b1;
    assign accept = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_limit_reg <= wsdm_pkg::STOP_LIMIT_RST;
            switch_limit_reg <= wsdm_pkg::SWITCH_LIMIT_RST;
            circ_reg <= wsdm_pkg::CIRC_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wsdm_pkg::CFG_STOP_LIMIT:   stop_limit_reg <= cfg_data;
                wsdm_pkg::CFG_SWITCH_LIMIT: switch_limit_reg <= cfg_data;
                wsdm_pkg::CFG_CIRC:         circ_reg <= cfg_data[wsdm_pkg::CIRC_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wsdm_pkg::ST_IDLE:
                if (in_valid)
                    state_next = reed_event ? wsdm_pkg::ST_PERIOD : wsdm_pkg::ST_DONE;
            wsdm_pkg::ST_PERIOD:
                if (per_done)
                    state_next = wsdm_pkg::ST_DIV;
            wsdm_pkg::ST_DIV:
                if (div_done)
                    state_next = wsdm_pkg::ST_DONE;
            wsdm_pkg::ST_DONE:
                if (out_free)
                    state_next = wsdm_pkg::ST_IDLE;
            default:
                state_next = wsdm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        per_start = 1'b0;
        div_start = 1'b0;
        commit = 1'b0;
        case (state_reg)
            wsdm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                per_start = in_valid && reed_event;
            end
            wsdm_pkg::ST_PERIOD:
                div_start = per_done;
            wsdm_pkg::ST_DIV:
                ;
            wsdm_pkg::ST_DONE:
                commit = out_free;
            default:
                ;
        endcase
    end

    // circumference * 1000 as shifts
    assign num = {circ_reg, 10'b0} - wsdm_pkg::NUM_W'({circ_reg, 4'b0})
               - wsdm_pkg::NUM_W'({circ_reg, 3'b0});

    wsdm_period #(
        .TS_W(TIMESTAMP_BITS)
    ) u_period (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (per_start),
        .now    (time_now_us),
        .done   (per_done),
        .period (period)
    );

    wsdm_div #(
        .PER_W(PER_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .period   (period),
        .num      (num),
        .done     (div_done),
        .quotient (quotient)
    );

    // Tick counter and speed magnitude for this tick
    always_comb
    begin
        tsp_inc = (tsp_reg == '1) ? tsp_reg : tsp_reg + 1'b1;
        if (reed_reg)
        begin
            tsp_next = '0;
            speed_next = quotient;
        end
        else
        begin
            tsp_next = tsp_inc;
            speed_next = (CMP_W'(tsp_inc) > CMP_W'(stop_limit_reg)) ? '0 : speed_reg;
        end
    end

    assign mode_req.upd = commit;
    assign mode_req.sys = sys_reg;
    assign mode_req.ped = ped_reg;

    wsdm_mode #(
        .CNT_W(COUNTER_BITS)
    ) u_mode (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (mode_req),
        .speed        (speed_next),
        .switch_limit (switch_limit_reg),
        .res          (mode_res)
    );

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsdm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            tsp_reg <= '0;
            speed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                tsp_reg <= tsp_next;
                speed_reg <= speed_next;
            end
        end
    end

    // Captured tick fields and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            reed_reg <= reed_event;
            sys_reg <= system_on;
            ped_reg <= pedaling;
        end
        if (commit)
        begin
            sspeed_reg <= mode_res.signed_speed;
            mode_reg <= mode_res.mode;
            hold_reg <= mode_res.hold;
            recup_reg <= mode_res.recup;
            rev_reg <= mode_res.rev;
        end
    end

    assign out_valid = out_valid_reg;
    assign signed_speed_mm_s = sspeed_reg;
    assign drive_mode = mode_reg;
    assign hold_ticks = hold_reg;
    assign recuperation_active = recup_reg;
    assign reverse_active = rev_reg;

    // Checks
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(recuperation_active && reverse_active))
        else $error("recuperation and reverse both active");

    a_per_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        per_done |-> (state_reg == wsdm_pkg::ST_PERIOD))
        else $error("period unit finished outside the period state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == wsdm_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == wsdm_pkg::ST_DONE))
        else $error("result shown without finishing an item");

endmodule
